/* rtl/rational_arith_reduce_macros.svh */
// Assertion macros for the rational arithmetic reduce block.
`ifndef RATIONAL_ARITH_REDUCE_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_MACROS_SVH

// Check a same-cycle implication, clocked on clk, off during reset.
`define RAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the following cycle, clocked on clk, off during reset.
`define RAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rar_pkg.sv */
// Shared types and codes for the rational arithmetic reduce block.
`default_nettype none

package rar_pkg;

    // Operation codes carried on the kind field.
    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_SETUP,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_FIN
    } state_t;

    localparam int CNT_BITS = 6;
    localparam int SHF_BITS = 7;

endpackage

`default_nettype wire

/* rtl/rational_arith_reduce.sv */
// Top level: rational add/sub/mul/div with binary GCD reduction.
// Steps: multiply states ST_MUL0 to ST_MUL2, a setup state, binary GCD steps (shift or
// subtract on one shared 65-bit subtractor), 2 x 64 restoring divide steps
// on the same subtractor, then an output state; a zero part skips GCD and divides.
// Throughput: one item at a time; the next item is taken once the result
// sits in the output register. Reset (rst_n low, async) empties the block.
`default_nettype none
`include "rational_arith_reduce_macros.svh"

module rational_arith_reduce #(
    parameter int WORD_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         kind,
    input  wire logic signed [31:0] a_num,
    input  wire logic [30:0]        a_den,
    input  wire logic signed [31:0] b_num,
    input  wire logic [30:0]        b_den,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      res_num,
    output logic [30:0]             res_den,
    output logic                    div_zero,
    output logic                    overflow
);

    localparam int SH = 32 - WORD_BITS;
    localparam logic [63:0] LIM = 64'(1) << (WORD_BITS - 1);

    rar_pkg::state_t state_reg, state_next;

    rar_pkg::kind_t      kind_reg;
    logic signed [31:0]  an_reg, bn_reg;
    logic [30:0]         ad_reg, bd_reg;
    logic signed [63:0]  pa_reg, pb_reg;
    logic signed [63:0]  rn_reg, rd_reg;
    logic [63:0]         nmag_reg, dmag_reg;
    logic [63:0]         u_reg, v_reg, rem_reg;
    logic [rar_pkg::SHF_BITS-1:0] k_reg;
    logic [rar_pkg::CNT_BITS-1:0] cnt_reg;
    logic                neg_reg, dz_reg;
    logic                out_valid_reg;
    logic signed [31:0]  res_num_reg;
    logic [30:0]         res_den_reg;
    logic                div_zero_reg, overflow_reg;

    logic                in_xfer, out_free, load_out;
    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  mul_p;
    logic [64:0]         sub_a, sub_b;
    logic [65:0]         sub_res;
    logic [64:0]         rem_sh;
    logic                div_ok;
    logic [63:0]         q_new;
    logic [63:0]         rn_mag, rd_mag;
    logic [63:0]         val;
    logic [31:0]         val_lo;
    logic signed [31:0]  sx;
    logic                ovf;
    logic [63:0]         lim_m1;

    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = (state_reg != rar_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = (state_reg == rar_pkg::ST_FIN) && out_free;

    // Select multiplier operands per step.
    always_comb
    begin
        mul_a = {an_reg[31], an_reg};
        mul_b = {2'b00, bd_reg};
        unique case (state_reg)
            rar_pkg::ST_MUL0:
            begin
                mul_a = {an_reg[31], an_reg};
                mul_b = (kind_reg == rar_pkg::KIND_MUL) ? {bn_reg[31], bn_reg}
                                                        : {2'b00, bd_reg};
            end
            rar_pkg::ST_MUL1:
            begin
                mul_a = {2'b00, ad_reg};
                mul_b = (kind_reg == rar_pkg::KIND_MUL) ? {2'b00, bd_reg}
                                                        : {bn_reg[31], bn_reg};
            end
            default:
            begin
                mul_a = {2'b00, ad_reg};
                mul_b = {2'b00, bd_reg};
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Drive the shared subtractor: GCD compare/subtract or divide step.
    assign rem_sh = {rem_reg, v_reg[63]};
    always_comb
    begin
        if (state_reg == rar_pkg::ST_GCD)
        begin
            sub_a = {1'b0, u_reg};
            sub_b = {1'b0, v_reg};
        end
        else
        begin
            sub_a = rem_sh;
            sub_b = {1'b0, u_reg};
        end
    end
    assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
    assign div_ok  = !sub_res[65];
    assign q_new   = {v_reg[62:0], div_ok};

    // Magnitudes of the raw result.
    assign rn_mag = rn_reg[63] ? 64'(-rn_reg) : 64'(rn_reg);
    assign rd_mag = rd_reg[63] ? 64'(-rd_reg) : 64'(rd_reg);

    // Fit the reduced result to the word and flag overflow.
    assign lim_m1 = LIM - 64'd1;
    assign ovf    = (dmag_reg > lim_m1) || (neg_reg ? (nmag_reg > LIM) : (nmag_reg > lim_m1));
    assign val    = neg_reg ? (64'd0 - nmag_reg) : nmag_reg;
    assign val_lo = val[31:0] << SH;
    assign sx     = $signed(val_lo) >>> SH;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rar_pkg::ST_IDLE:  if (in_xfer) state_next = rar_pkg::ST_MUL0;
            rar_pkg::ST_MUL0:  state_next = rar_pkg::ST_MUL1;
            rar_pkg::ST_MUL1:  state_next = rar_pkg::ST_MUL2;
            rar_pkg::ST_MUL2:  state_next = rar_pkg::ST_SETUP;
            rar_pkg::ST_SETUP:
            begin
                if (rn_mag == 64'd0 || rd_mag == 64'd0)
                    state_next = rar_pkg::ST_FIN;
                else
                    state_next = rar_pkg::ST_GCD;
            end
            rar_pkg::ST_GCD:   if (v_reg == 64'd0) state_next = rar_pkg::ST_DIVN;
            rar_pkg::ST_DIVN:  if (&cnt_reg) state_next = rar_pkg::ST_DIVD;
            rar_pkg::ST_DIVD:  if (&cnt_reg) state_next = rar_pkg::ST_FIN;
            rar_pkg::ST_FIN:   if (out_free) state_next = rar_pkg::ST_IDLE;
            default:           state_next = rar_pkg::ST_IDLE;
        endcase
    end

    // Hold control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rar_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Advance the datapath.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            rar_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    kind_reg <= rar_pkg::kind_t'(kind);
                    an_reg   <= a_num;
                    ad_reg   <= a_den;
                    bn_reg   <= b_num;
                    bd_reg   <= b_den;
                end
            end
            rar_pkg::ST_MUL0: pa_reg <= mul_p[63:0];
            rar_pkg::ST_MUL1: pb_reg <= mul_p[63:0];
            rar_pkg::ST_MUL2:
            begin
                unique case (kind_reg)
                    rar_pkg::KIND_ADD:
                    begin
                        rn_reg <= pa_reg + pb_reg;
                        rd_reg <= mul_p[63:0];
                    end
                    rar_pkg::KIND_SUB:
                    begin
                        rn_reg <= pa_reg - pb_reg;
                        rd_reg <= mul_p[63:0];
                    end
                    default:
                    begin
                        rn_reg <= pa_reg;
                        rd_reg <= pb_reg;
                    end
                endcase
            end
            rar_pkg::ST_SETUP:
            begin
                dz_reg <= (rd_mag == 64'd0);
                u_reg  <= rn_mag;
                v_reg  <= rd_mag;
                k_reg  <= '0;
                if (rn_mag == 64'd0)
                begin
                    nmag_reg <= 64'd0;
                    dmag_reg <= 64'd1;
                    neg_reg  <= 1'b0;
                end
                else
                begin
                    nmag_reg <= rn_mag;
                    dmag_reg <= rd_mag;
                    neg_reg  <= (rd_mag == 64'd0) ? rn_reg[63] : (rn_reg[63] ^ rd_reg[63]);
                end
            end
            rar_pkg::ST_GCD:
            begin
                priority if (v_reg == 64'd0)
                begin
                    u_reg   <= u_reg << k_reg;
                    v_reg   <= nmag_reg;
                    rem_reg <= 64'd0;
                    cnt_reg <= '0;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_reg <= u_reg >> 1;
                    v_reg <= v_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end
                else if (!u_reg[0])
                    u_reg <= u_reg >> 1;
                else if (!v_reg[0])
                    v_reg <= v_reg >> 1;
                else if (!sub_res[65])
                begin
                    if (sub_res[63:0] == 64'd0)
                        v_reg <= 64'd0;
                    else
                        u_reg <= sub_res[63:0];
                end
                else
                    v_reg <= 64'd0 - sub_res[63:0];
            end
            rar_pkg::ST_DIVN, rar_pkg::ST_DIVD:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (&cnt_reg)
                begin
                    rem_reg <= 64'd0;
                    v_reg   <= dmag_reg;
                    if (state_reg == rar_pkg::ST_DIVN)
                        nmag_reg <= q_new;
                    else
                        dmag_reg <= q_new;
                end
                else
                begin
                    rem_reg <= div_ok ? sub_res[63:0] : rem_sh[63:0];
                    v_reg   <= q_new;
                end
            end
            rar_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    res_num_reg  <= sx;
                    res_den_reg  <= dmag_reg[30:0] & lim_m1[30:0];
                    div_zero_reg <= dz_reg;
                    overflow_reg <= ovf;
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign div_zero  = div_zero_reg;
    assign overflow  = overflow_reg;

    `RAR_ASSERT_NEXT(a_accept_starts, in_xfer, state_reg == rar_pkg::ST_MUL0, "accept did not start multiply")
    `RAR_ASSERT_NOW(a_gcd_nonzero, state_reg == rar_pkg::ST_GCD, u_reg != 64'd0, "GCD operand reached zero")
    `RAR_ASSERT_NEXT(a_out_drain, out_valid_reg && !out_stall && !load_out, !out_valid_reg, "taken result not dropped")
    `RAR_ASSERT_NOW(a_zero_den, out_valid_reg && res_den_reg == 31'd0, div_zero_reg || overflow_reg, "zero denominator unflagged")

endmodule

`default_nettype wire

/* test/rational_arith_reduce_tb.sv */
// Testbench for the rational arithmetic reduce block: random and directed operands.
`default_nettype none

module rational_arith_reduce_tb;

    // Expected reduced fraction and flags for one operation.
    typedef struct {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic               dz;
        logic               ovf;
    } ratio_t;

    // Reduced-fraction scoreboard: predict on input transfer, compare on output.
    class ratio_board;
        ratio_t pending[$];
        int     errors;

        function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
            logic [63:0] t;
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        function void note_operands(rar_pkg::kind_t k, logic signed [31:0] an,
                                    logic [30:0] ad, logic signed [31:0] bn,
                                    logic [30:0] bd);
            logic signed [63:0] rn, rd, sad, sbd;
            logic [63:0] nm, dm, g, lim, v;
            logic neg;
            ratio_t r;
            sad = {33'd0, ad};
            sbd = {33'd0, bd};
            case (k)
                rar_pkg::KIND_ADD: begin rn = an * sbd + bn * sad; rd = sad * sbd; end
                rar_pkg::KIND_SUB: begin rn = an * sbd - bn * sad; rd = sad * sbd; end
                rar_pkg::KIND_MUL: begin rn = 64'(an) * 64'(bn); rd = sad * sbd; end
                default:  begin rn = an * sbd; rd = sad * 64'(bn); end
            endcase
            nm = rn < 0 ? -rn : rn;
            dm = rd < 0 ? -rd : rd;
            r.dz = (dm == 0);
            if (nm == 0)
            begin
                dm = 1;
                neg = 0;
            end
            else if (dm == 0)
                neg = rn < 0;
            else
            begin
                g = gcd64(nm, dm);
                nm = nm / g;
                dm = dm / g;
                neg = (rn < 0) != (rd < 0);
            end
            lim = 64'd1 << 31;
            r.ovf = (dm > lim - 1) || (neg ? nm > lim : nm > lim - 1);
            v = neg ? -nm : nm;
            r.num = v[31:0];
            r.den = dm[30:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic signed [31:0] n, logic [30:0] d, logic z, logic o);
            ratio_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %0d/%0d", $time, n, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (n !== e.num)
            begin
                $display("%0t: res_num expected %0d actual %0d", $time, e.num, n);
                errors++;
            end
            if (d !== e.den)
            begin
                $display("%0t: res_den expected %0d actual %0d", $time, e.den, d);
                errors++;
            end
            if (z !== e.dz)
            begin
                $display("%0t: div_zero expected %0b actual %0b", $time, e.dz, z);
                errors++;
            end
            if (o !== e.ovf)
            begin
                $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, o);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [1:0] kind;
    logic signed [31:0] a_num, b_num, res_num;
    logic [30:0] a_den, b_den, res_den;
    logic div_zero, overflow;

    int send_idle_pct, recv_idle_pct;
    bit hold_off;
    longint cycles;
    ratio_board board;

    rational_arith_reduce DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .out_valid(out_valid), .out_stall(out_stall),
        .res_num(res_num), .res_den(res_den), .div_zero(div_zero), .overflow(overflow)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Send one operation, with optional idle cycles before it.
    task automatic send_op(rar_pkg::kind_t k, logic signed [31:0] an, logic [30:0] ad,
                           logic signed [31:0] bn, logic [30:0] bd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        kind <= k;
        a_num <= an;
        a_den <= ad;
        b_num <= bn;
        b_den <= bd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_operands(k, an, ad, bn, bd);
    endtask

    function automatic logic signed [31:0] rand_num();
        case ($urandom_range(3))
            0: return $signed($urandom());
            1: return $signed(32'($urandom_range(40))) - 20;
            2: return $signed($urandom_range(1, 3) == 1 ? 32'h8000_0000 : 32'h7fff_ffff);
            default: return $signed(32'($urandom_range(2000))) - 1000;
        endcase
    endfunction

    function automatic logic [30:0] rand_den();
        case ($urandom_range(3))
            0: return 31'($urandom());
            1: return 31'($urandom_range(1, 30));
            2: return 31'h7fff_ffff;
            default: return 31'($urandom_range(1, 1000));
        endcase
    endfunction

    task automatic send_random(int count);
        repeat (count)
            send_op(rar_pkg::kind_t'($urandom_range(3)), rand_num(), rand_den(),
                    rand_num(), rand_den());
    endtask

    // Drop the input, drain the result queue and let the block settle.
    task automatic wait_drained();
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (450) @(posedge clk);
    endtask

    // Receiver stall: random by percentage, or held during a long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 0;
        else
            out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    // Check every output transfer.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(res_num, res_den, div_zero, overflow);
    end

    // Bound the run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 2000000)
        begin
            $display("rational_arith_reduce test failed");
            $finish;
        end
    end

    // Hold the receiver off for a long stretch while items keep coming.
    initial
    begin
        hold_off = 0;
        wait (cycles > 3000);
        @(posedge clk);
        hold_off <= 1;
        repeat (600) @(posedge clk);
        hold_off <= 0;
    end

    initial
    begin
        board = new();
        cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 0;
        in_valid = 0;
        kind = rar_pkg::KIND_ADD;
        a_num = 0;
        a_den = 1;
        b_num = 0;
        b_den = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, every operation, zero numerators and zero divisors.
        send_op(rar_pkg::KIND_ADD, 1, 2, 1, 3);
        send_op(rar_pkg::KIND_SUB, 1, 2, 1, 2);
        send_op(rar_pkg::KIND_MUL, -4, 6, 3, 8);
        send_op(rar_pkg::KIND_DIV, 3, 4, -9, 8);
        send_op(rar_pkg::KIND_DIV, 5, 7, 0, 3);
        send_op(rar_pkg::KIND_DIV, 0, 7, 0, 3);
        send_op(rar_pkg::KIND_MUL, 0, 31'h7fff_ffff, -5, 1);
        send_op(rar_pkg::KIND_MUL, 32'sh8000_0000, 1, 32'sh8000_0000, 1);
        send_op(rar_pkg::KIND_MUL, 32'sh7fff_ffff, 1, 32'sh7fff_ffff, 1);
        send_op(rar_pkg::KIND_ADD, 32'sh7fff_ffff, 1, 32'sh7fff_ffff, 1);
        send_op(rar_pkg::KIND_SUB, 32'sh8000_0000, 1, 1, 1);
        send_op(rar_pkg::KIND_ADD, 1, 31'h7fff_ffff, 1, 31'h7fff_fffe);
        send_op(rar_pkg::KIND_DIV, 32'sh8000_0000, 1, -1, 1);
        send_op(rar_pkg::KIND_DIV, 1, 31'h7fff_ffff, 32'sh8000_0000, 31'h7fff_ffff);
        send_op(rar_pkg::KIND_ADD, 3, 0, 2, 5);
        send_op(rar_pkg::KIND_MUL, -1, 1, -1, 1);
        send_op(rar_pkg::KIND_SUB, -6, 4, 6, 4);
        send_op(rar_pkg::KIND_DIV, -12, 18, 4, 6);

        // Random phases with shifting idle patterns.
        send_idle_pct = 15;
        recv_idle_pct = 67;
        send_random(200);
        wait_drained();
        send_idle_pct = 67;
        recv_idle_pct = 15;
        send_random(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(200);
        wait_drained();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("rational_arith_reduce test passed");
        else
            $display("rational_arith_reduce test failed");
        $finish;
    end
endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/rar_pkg.sv
rtl/rational_arith_reduce.sv
test/rational_arith_reduce_tb.sv
